// ----- design/rzca_pkg.sv -----
// Shared types and constants for the reverb zone containment and average block.
// Holds stream layout widths, command and shape codes, controller state and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package rzca_pkg;

   localparam int ZONES_DEF   = 16;
   localparam int REQ_DATA_W  = 168;
   localparam int RSP_DATA_W  = 72;
   localparam int CRD_W       = 32;
   localparam int EXT_W       = 31;
   localparam int LVL_W       = 16;
   localparam int MAG_W       = 36;
   localparam int PROD_W      = 64;
   localparam int ACC_W       = 66;
   localparam int ACTIVE_W    = 5;

   localparam logic [1:0] CMD_CENTER = 2'd0;
   localparam logic [1:0] CMD_EXTENT = 2'd1;
   localparam logic [1:0] CMD_LEVELS = 2'd2;
   localparam logic [1:0] CMD_QUERY  = 2'd3;

   localparam logic [1:0] SHAPE_SPHERE  = 2'd0;
   localparam logic [1:0] SHAPE_BOX     = 2'd1;
   localparam logic [1:0] SHAPE_CAPSULE = 2'd2;

   typedef enum logic [1:0] {
      MS_X = 2'd0,
      MS_Y = 2'd1,
      MS_Z = 2'd2,
      MS_L = 2'd3
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD = 2'd0,
      ACC_LOAD = 2'd1,
      ACC_ADD  = 2'd2
   } acc_op_type;

   typedef enum logic [10:0] {
      S_IDLE  = 11'b000_0000_0001,
      S_READ  = 11'b000_0000_0010,
      S_DIFF  = 11'b000_0000_0100,
      S_SQX   = 11'b000_0000_1000,
      S_SQY   = 11'b000_0001_0000,
      S_SQZ   = 11'b000_0010_0000,
      S_SQL   = 11'b000_0100_0000,
      S_TEST  = 11'b000_1000_0000,
      S_DIVLD = 11'b001_0000_0000,
      S_DIV   = 11'b010_0000_0000,
      S_OUT   = 11'b100_0000_0000
   } state_type;

   typedef struct packed {
      logic        wr;
      logic        start_q;
      logic        rd;
      logic        diff;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        test;
      logic        next_zone;
      logic        div_load;
      logic        div_step;
      logic        load_rsp;
   } ctl_type;

   typedef struct packed {
      logic last_zone;
      logic div_last;
      logic rsp_busy;
   } sts_type;

endpackage

`default_nettype wire

// ----- design/reverb_zone_containment_average.sv -----
// Top level of the reverb zone containment and average block.
// Instantiates rzca_ctrl and rzca_datapath; depends on rzca_pkg.
//
// Write requests (center, extents/shape/enable, levels) are taken in the idle state.
// A query walks the zone table one zone at a time through the table read, the
// difference stage and the one shared 32x32 squarer, then runs a restoring
// divider of 16+clog2(ZONES+1) steps over four lanes and hands the result off.
// The result register lets the next request in while a result waits.
`default_nettype none

module reverb_zone_containment_average
   import rzca_pkg::*;
#(
   parameter int ZONES = ZONES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // tdata from bit 0: zone[4], shape[2], enabled[1], coord_x[32], coord_y[32],
   // coord_z[32], wet_level[16], dry_level[16], room_size[16], damping[16], pad
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: cmd[2]
   input  wire logic [1:0]            req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // tdata from bit 0: active_zones[5], avg_wet[16], avg_dry[16], avg_room[16],
   // avg_damping[16], pad
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   ctl_type ctl;
   sts_type sts;

   rzca_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .sts        (sts),
      .ctl        (ctl)
   );

   rzca_datapath #(
      .ZONES (ZONES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_cmd    (req_tuser),
      .ctl        (ctl),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // A result appears only from the hand-off step
   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(ctl.load_rsp))
      else $error("result raised without a load");

   // No request is taken while the divider runs
   a_no_accept_div: assert property (@(posedge clock) disable iff (reset)
      ctl.div_step |-> !req_tready)
      else $error("request accepted during division");

   // An empty zone set reports zero levels
   a_zero_avg: assert property (@(posedge clock) disable iff (reset)
      (ZONES < 32 && rsp_tvalid && rsp_tdata[4:0] == 5'd0) |->
      (rsp_tdata[68:5] == 64'd0))
      else $error("non-zero average with no active zone");

endmodule

`default_nettype wire

// ----- design/rzca_ctrl.sv -----
// Controller state machine for the reverb zone block: sequences writes, the
// per-zone containment walk, the division pass and the result hand-off.
// Depends on rzca_pkg.
`default_nettype none

module rzca_ctrl
   import rzca_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   input  wire logic [1:0] req_tuser,
   output logic            req_tready,
   input  wire sts_type    sts,
   output ctl_type         ctl
);

   state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      ctl          = '0;
      ctl.mul_sel  = MS_X;
      ctl.acc_op   = ACC_HOLD;
      req_tready   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser == CMD_QUERY) begin
                  ctl.start_q = 1'b1;
                  state_in    = S_READ;
               end else begin
                  ctl.wr = 1'b1;
               end
            end
         end
         S_READ: begin
            ctl.rd   = 1'b1;
            state_in = S_DIFF;
         end
         S_DIFF: begin
            ctl.diff = 1'b1;
            state_in = S_SQX;
         end
         S_SQX: begin
            ctl.mul_sel = MS_X;
            state_in    = S_SQY;
         end
         S_SQY: begin
            ctl.mul_sel = MS_Y;
            ctl.acc_op  = ACC_LOAD;
            state_in    = S_SQZ;
         end
         S_SQZ: begin
            ctl.mul_sel = MS_Z;
            ctl.acc_op  = ACC_ADD;
            state_in    = S_SQL;
         end
         S_SQL: begin
            ctl.mul_sel = MS_L;
            ctl.acc_op  = ACC_ADD;
            state_in    = S_TEST;
         end
         S_TEST: begin
            ctl.test = 1'b1;
            if (sts.last_zone) begin
               state_in = S_DIVLD;
            end else begin
               ctl.next_zone = 1'b1;
               state_in      = S_READ;
            end
         end
         S_DIVLD: begin
            ctl.div_load = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            ctl.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // hold until the previous result has been taken
            if (!sts.rsp_busy) begin
               ctl.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/rzca_datapath.sv -----
// Datapath for the reverb zone block: zone table memories, containment test
// with one shared squarer, level sums, a four-lane restoring divider and the
// result register. Depends on rzca_pkg.
`default_nettype none

module rzca_datapath
   import rzca_pkg::*;
#(
   parameter int ZONES = ZONES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [1:0]            req_cmd,
   input  wire ctl_type               ctl,
   output sts_type                    sts,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   localparam int ZIDX_W = (ZONES > 1) ? $clog2(ZONES) : 1;
   localparam int CNT_W  = $clog2(ZONES + 1);
   localparam int SUM_W  = LVL_W + CNT_W;
   localparam int DCNT_W = $clog2(SUM_W + 1);
   localparam int REM_W  = CNT_W + 1;

   // Unpack request
   logic        [3:0]       f_zone;
   logic        [1:0]       f_shape;
   logic                    f_en;
   logic signed [CRD_W-1:0] f_x, f_y, f_z;
   logic        [4*LVL_W-1:0] f_lvl;
   assign f_zone  = req_tdata[3:0];
   assign f_shape = req_tdata[5:4];
   assign f_en    = req_tdata[6];
   assign f_x     = req_tdata[38:7];
   assign f_y     = req_tdata[70:39];
   assign f_z     = req_tdata[102:71];
   assign f_lvl   = req_tdata[166:103];

   logic [7:0]        zone8;
   logic [ZIDX_W-1:0] widx;
   logic              zone_ok;
   assign zone8   = {4'b0, f_zone};
   assign widx    = zone8[ZIDX_W-1:0];
   assign zone_ok = 32'(zone8) < ZONES;

   // Zone table
   logic [3*CRD_W-1:0] center_mem [ZONES];
   logic [3*EXT_W-1:0] extent_mem [ZONES];
   logic [4*LVL_W-1:0] levels_mem [ZONES];
   logic [1:0]         shape_mem  [ZONES];
   logic [ZONES-1:0]   en_ff;

   logic [EXT_W-1:0] ex_w, ey_w, ez_w;
   assign ex_w = f_x[CRD_W-1] ? '0 : f_x[EXT_W-1:0];
   assign ey_w = f_y[CRD_W-1] ? '0 : f_y[EXT_W-1:0];
   assign ez_w = f_z[CRD_W-1] ? '0 : f_z[EXT_W-1:0];

   logic [1:0] wcmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff <= '0;
      end else if (ctl.wr && zone_ok && wcmd == CMD_EXTENT) begin
         en_ff[widx] <= f_en;
      end
   end

   // Query state and position
   logic signed [CRD_W-1:0]  px_ff, py_ff, pz_ff;
   logic        [ZIDX_W-1:0] zcnt_ff;

   always_ff @(posedge clock) begin
      if (ctl.start_q) begin
         px_ff <= f_x;
         py_ff <= f_y;
         pz_ff <= f_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zcnt_ff <= '0;
      end else if (ctl.start_q) begin
         zcnt_ff <= '0;
      end else if (ctl.next_zone) begin
         zcnt_ff <= zcnt_ff + 1'b1;
      end
   end
   assign sts.last_zone = zcnt_ff == ZIDX_W'(ZONES - 1);

   // Registered table read
   logic [3*CRD_W-1:0] c_rd_ff;
   logic [3*EXT_W-1:0] e_rd_ff;
   logic [4*LVL_W-1:0] l_rd_ff;
   logic [1:0]         s_rd_ff;
   logic               en_rd_ff;

   always_ff @(posedge clock) begin
      if (ctl.rd) begin
         c_rd_ff  <= center_mem[zcnt_ff];
         e_rd_ff  <= extent_mem[zcnt_ff];
         l_rd_ff  <= levels_mem[zcnt_ff];
         s_rd_ff  <= shape_mem[zcnt_ff];
         en_rd_ff <= en_ff[zcnt_ff];
      end
   end

   // Differences, magnitudes and limit for this zone
   logic signed [MAG_W-1:0] cx, cy, cz, dx, dy, dz, y2, lo, hi, d2;
   logic        [MAG_W-1:0] ax, ay, az, mx, my, mz, lim, ex, ey, ez;
   logic                    box_ok;

   always_comb begin
      cx  = MAG_W'(signed'(c_rd_ff[CRD_W-1:0]));
      cy  = MAG_W'(signed'(c_rd_ff[2*CRD_W-1:CRD_W]));
      cz  = MAG_W'(signed'(c_rd_ff[3*CRD_W-1:2*CRD_W]));
      ex  = MAG_W'(e_rd_ff[EXT_W-1:0]);
      ey  = MAG_W'(e_rd_ff[2*EXT_W-1:EXT_W]);
      ez  = MAG_W'(e_rd_ff[3*EXT_W-1:2*EXT_W]);
      dx  = MAG_W'(px_ff) - cx;
      dy  = MAG_W'(py_ff) - cy;
      dz  = MAG_W'(pz_ff) - cz;
      ax  = dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
      ay  = dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
      az  = dz[MAG_W-1] ? MAG_W'(-dz) : MAG_W'(dz);
      box_ok = ((ax << 1) <= ex) && ((ay << 1) <= ey) && ((az << 1) <= ez);
      y2  = MAG_W'(py_ff) <<< 1;
      lo  = (cy <<< 1) - signed'(ey);
      hi  = (cy <<< 1) + signed'(ey);
      if (y2 < lo) begin
         d2 = lo - y2;
      end else if (y2 > hi) begin
         d2 = y2 - hi;
      end else begin
         d2 = '0;
      end
      if (s_rd_ff == SHAPE_CAPSULE) begin
         mx  = ax << 1;
         my  = MAG_W'(d2);
         mz  = az << 1;
         lim = ex << 1;
      end else begin
         mx  = ax;
         my  = ay;
         mz  = az;
         lim = ex;
      end
   end

   logic [CRD_W-1:0] mx_ff, my_ff, mz_ff, lim_ff;
   logic             pre_ok_ff, box_ok_ff, en_t_ff;
   logic [1:0]       shape_t_ff;

   always_ff @(posedge clock) begin
      if (ctl.diff) begin
         mx_ff      <= mx[CRD_W-1:0];
         my_ff      <= my[CRD_W-1:0];
         mz_ff      <= mz[CRD_W-1:0];
         lim_ff     <= lim[CRD_W-1:0];
         pre_ok_ff  <= (mx <= lim) && (my <= lim) && (mz <= lim);
         box_ok_ff  <= box_ok;
         en_t_ff    <= en_rd_ff;
         shape_t_ff <= s_rd_ff;
      end
   end

   // Shared squarer and sum of squares
   logic [CRD_W-1:0]  mul_a;
   logic [PROD_W-1:0] prod_ff;
   logic [ACC_W-1:0]  acc_ff;

   always_comb begin
      case (ctl.mul_sel)
         MS_X:    mul_a = mx_ff;
         MS_Y:    mul_a = my_ff;
         MS_Z:    mul_a = mz_ff;
         MS_L:    mul_a = lim_ff;
         default: mul_a = lim_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_a);
      case (ctl.acc_op)
         ACC_LOAD: acc_ff <= ACC_W'(prod_ff);
         ACC_ADD:  acc_ff <= acc_ff + ACC_W'(prod_ff);
         default:  acc_ff <= acc_ff;
      endcase
   end

   // Containment decision
   logic hit;
   always_comb begin
      case (shape_t_ff)
         SHAPE_SPHERE, SHAPE_CAPSULE: hit = pre_ok_ff && (acc_ff <= ACC_W'(prod_ff));
         SHAPE_BOX:                   hit = box_ok_ff;
         default:                     hit = 1'b0;
      endcase
      hit = hit && en_t_ff;
   end

   // Level sums and count
   logic [SUM_W-1:0] sum_ff [4];
   logic [CNT_W-1:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (ctl.start_q) begin
         cnt_ff <= '0;
         for (int j = 0; j < 4; j++) begin
            sum_ff[j] <= '0;
         end
      end else if (ctl.test && hit) begin
         cnt_ff <= cnt_ff + 1'b1;
         for (int j = 0; j < 4; j++) begin
            sum_ff[j] <= sum_ff[j] + SUM_W'(l_rd_ff[j*LVL_W +: LVL_W]);
         end
      end
   end

   // Restoring divider, one quotient bit per cycle in each lane
   logic [SUM_W-1:0]  quo_ff [4];
   logic [REM_W-1:0]  rem_ff [4];
   logic [DCNT_W-1:0] dcnt_ff;
   logic [REM_W-1:0]  trial [4];
   logic              qbit [4];

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         trial[j] = {rem_ff[j][REM_W-2:0], quo_ff[j][SUM_W-1]};
         qbit[j]  = trial[j] >= REM_W'(cnt_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.div_load) begin
         dcnt_ff <= '0;
         for (int j = 0; j < 4; j++) begin
            quo_ff[j] <= sum_ff[j];
            rem_ff[j] <= '0;
         end
      end else if (ctl.div_step) begin
         dcnt_ff <= dcnt_ff + 1'b1;
         for (int j = 0; j < 4; j++) begin
            quo_ff[j] <= {quo_ff[j][SUM_W-2:0], qbit[j]};
            rem_ff[j] <= qbit[j] ? trial[j] - REM_W'(cnt_ff) : trial[j];
         end
      end
   end
   assign sts.div_last = dcnt_ff == DCNT_W'(SUM_W - 1);

   // Result register
   logic                  rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [7:0]            cnt8;
   logic [4*LVL_W-1:0]    avg;

   assign cnt8 = 8'(cnt_ff);
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         avg[j*LVL_W +: LVL_W] = (cnt_ff == '0) ? '0 : quo_ff[j][LVL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (ctl.load_rsp) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_rsp) begin
         rsp_data_ff <= {3'b0, avg, cnt8[ACTIVE_W-1:0]};
      end
   end

   assign sts.rsp_busy = rsp_tvalid_ff && !rsp_tready;
   assign rsp_tvalid   = rsp_tvalid_ff;
   assign rsp_tdata    = rsp_data_ff;

   // Table writes, selected by the request command
   always_ff @(posedge clock) begin
      if (ctl.wr && zone_ok) begin
         case (wcmd)
            CMD_CENTER: center_mem[widx] <= {f_z, f_y, f_x};
            CMD_EXTENT: begin
               extent_mem[widx] <= {ez_w, ey_w, ex_w};
               shape_mem[widx]  <= f_shape;
            end
            CMD_LEVELS: levels_mem[widx] <= f_lvl;
            default: ;
         endcase
      end
   end

   // Command of the current request, taken straight from tuser while a write is under way
   assign wcmd = ctl.wr ? req_cmd : CMD_QUERY;

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// Testbench for reverb_zone_containment_average: zone table writes and listener queries.
// Predicts each query result with its own zone table and checks the response stream.
// Depends on rzca_pkg and the reverb_zone_containment_average RTL.
`default_nettype none

module tb
   import rzca_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NZ          = 16;
   localparam int STALL_MAX   = 20000;
   localparam int HOLD_CYCLES = 600;

   typedef struct packed {
      logic [4:0]  active;
      logic [15:0] wet;
      logic [15:0] dry;
      logic [15:0] room;
      logic [15:0] damp;
   } zone_avg_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // model zone table
   logic              zon_en  [NZ];
   logic [1:0]        zon_shp [NZ];
   logic signed [31:0] zon_ctr [NZ][3];
   logic [30:0]       zon_ext [NZ][3];
   logic [15:0]       zon_lvl [NZ][4];
   bit                ctr_set [NZ];
   bit                lvl_set [NZ];

   zone_avg_type avg_queue[$];
   int  mismatches = 0;
   int  idle_cycles = 0;
   int  rsp_gap = 0;
   bit  rsp_idle_on = 1;
   bit  req_idle_on = 1;
   bit  hold_rsp = 0;

   always #5 clock = ~clock;

   reverb_zone_containment_average i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // sum of squares within lim^2, exact in 128 bits
   function automatic bit in_ball(longint unsigned ax, longint unsigned ay,
                                  longint unsigned az, longint unsigned lim);
      logic [127:0] s;
      s = 128'(ax) * ax + 128'(ay) * ay + 128'(az) * az;
      return s <= 128'(lim) * lim;
   endfunction

   function automatic longint unsigned absl(longint v);
      return v < 0 ? longint'(-v) : v;
   endfunction

   function automatic bit zone_holds(int k, longint px, longint py, longint pz);
      longint dx, dy, dz, y2, lo, hi, d2;
      dx = px - zon_ctr[k][0];
      dy = py - zon_ctr[k][1];
      dz = pz - zon_ctr[k][2];
      case (zon_shp[k])
         SHAPE_SPHERE:
            return in_ball(absl(dx), absl(dy), absl(dz), zon_ext[k][0]);
         SHAPE_BOX:
            return 2 * absl(dx) <= zon_ext[k][0] && 2 * absl(dy) <= zon_ext[k][1]
                && 2 * absl(dz) <= zon_ext[k][2];
         SHAPE_CAPSULE: begin
            y2 = 2 * py;
            lo = 2 * longint'(zon_ctr[k][1]) - zon_ext[k][1];
            hi = 2 * longint'(zon_ctr[k][1]) + zon_ext[k][1];
            d2 = 0;
            if (y2 < lo) d2 = lo - y2;
            else if (y2 > hi) d2 = y2 - hi;
            return in_ball(2 * absl(dx), d2, 2 * absl(dz), 2 * zon_ext[k][0]);
         end
         default: return 0;
      endcase
   endfunction

   // apply one request to the model; queue the expected average on a query
   task automatic predict_zone_request(logic [1:0] cmd, logic [3:0] k, logic [1:0] shp,
                                       logic en, logic signed [31:0] c[3],
                                       logic [15:0] l[4]);
      zone_avg_type r;
      int unsigned sum[4];
      int unsigned n;
      n = 0;
      sum = '{0, 0, 0, 0};
      case (cmd)
         CMD_CENTER: begin
            for (int i = 0; i < 3; i++) zon_ctr[k][i] = c[i];
            ctr_set[k] = 1;
         end
         CMD_EXTENT: begin
            for (int i = 0; i < 3; i++) zon_ext[k][i] = c[i] < 0 ? '0 : c[i][30:0];
            zon_shp[k] = shp;
            zon_en[k] = en;
         end
         CMD_LEVELS: begin
            for (int i = 0; i < 4; i++) zon_lvl[k][i] = l[i];
            lvl_set[k] = 1;
         end
         default: begin
            for (int z = 0; z < NZ; z++)
               if (zon_en[z] && zone_holds(z, c[0], c[1], c[2])) begin
                  for (int j = 0; j < 4; j++) sum[j] += zon_lvl[z][j];
                  n++;
               end
            r.active = n[4:0];
            r.wet  = n ? 16'(sum[0] / n) : '0;
            r.dry  = n ? 16'(sum[1] / n) : '0;
            r.room = n ? 16'(sum[2] / n) : '0;
            r.damp = n ? 16'(sum[3] / n) : '0;
            avg_queue = {avg_queue, r};
         end
      endcase
   endtask

   // drive one request and wait for acceptance
   task automatic send_request(logic [1:0] cmd, logic [3:0] k, logic [1:0] shp,
                               logic en, logic signed [31:0] c[3], logic [15:0] l[4]);
      int gap;
      // an enable write must not expose a zone that was never filled
      if (cmd == CMD_EXTENT && en && !(ctr_set[k] && lvl_set[k])) en = 1'b0;
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= cmd;
      req_tdata  <= {1'b0, l[3], l[2], l[1], l[0], c[2], c[1], c[0], en, shp, k};
      predict_zone_request(cmd, k, shp, en, c, l);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic signed [31:0] rnd_coord();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return $signed($urandom_range(0, 4000)) - 2000;
         default: return $signed($urandom_range(0, 40000)) - 20000;
      endcase
   endfunction

   task automatic random_zone(logic [3:0] k);
      logic signed [31:0] c[3];
      logic [15:0] l[4];
      for (int i = 0; i < 3; i++) c[i] = rnd_coord();
      for (int i = 0; i < 4; i++) l[i] = 16'($urandom);
      send_request(CMD_CENTER, k, 2'd0, 1'b0, c, l);
      send_request(CMD_LEVELS, k, 2'd0, 1'b0, c, l);
      for (int i = 0; i < 3; i++)
         c[i] = $urandom_range(0, 9) == 0 ? $urandom : $signed($urandom_range(0, 30000));
      send_request(CMD_EXTENT, k, 2'($urandom_range(0, 3)), $urandom_range(0, 4) != 0,
                   c, l);
   endtask

   task automatic random_query();
      logic signed [31:0] c[3];
      logic [15:0] l[4];
      for (int i = 0; i < 3; i++) c[i] = rnd_coord();
      for (int i = 0; i < 4; i++) l[i] = 16'($urandom);
      send_request(CMD_QUERY, 4'($urandom), 2'($urandom), 1'($urandom), c, l);
   endtask

   task automatic wait_drained();
      while (avg_queue.size() != 0) @(negedge clock);
   endtask

   // extremes: full-range coordinates, shape code three, negative extents
   task automatic test_directed();
      logic signed [31:0] c[3];
      logic [15:0] l[4];
      l = '{16'hFFFF, 16'hFFFF, 16'h0000, 16'h8001};
      c = '{32'sh7FFFFFFF, 32'sh80000000, 0};
      send_request(CMD_QUERY, 4'd0, 2'd0, 1'b0, c, l);
      for (int k = 0; k < 4; k++) begin
         c = '{0, 0, 0};
         send_request(CMD_CENTER, 4'(k), 2'd0, 1'b0, c, l);
         send_request(CMD_LEVELS, 4'(k), 2'd0, 1'b0, c, l);
         if (k == 3) c = '{32'sh80000000, -1, 32'sh7FFFFFFF};
         else c = '{32'sh7FFFFFFF, 1000, 1000};
         send_request(CMD_EXTENT, 4'(k), k[1:0], 1'b1, c, l);
      end
      c = '{0, 0, 0};
      send_request(CMD_QUERY, 4'd15, 2'd3, 1'b1, c, l);
      c = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF};
      send_request(CMD_QUERY, 4'd0, 2'd0, 1'b0, c, l);
      c = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
      send_request(CMD_QUERY, 4'd0, 2'd0, 1'b0, c, l);
      c = '{100, 500, 0};
      send_request(CMD_QUERY, 4'd0, 2'd0, 1'b0, c, l);
      // capsule with zero length behaves as a sphere
      c = '{400, 0, 0};
      send_request(CMD_EXTENT, 4'd2, SHAPE_CAPSULE, 1'b1, c, l);
      c = '{400, 0, 0};
      send_request(CMD_QUERY, 4'd0, 2'd0, 1'b0, c, l);
      c = '{0, 0, 401};
      send_request(CMD_QUERY, 4'd0, 2'd0, 1'b0, c, l);
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++)
         if ($urandom_range(0, 2) == 0) random_zone(4'($urandom));
         else random_query();
   endtask

   // hold the receiver off for a fixed stretch while requests keep coming
   task automatic test_backpressure();
      fork
         begin
            hold_rsp = 1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 0;
         end
      join_none
      for (int i = 0; i < 6; i++) random_query();
   endtask

   // receiver: random stall bursts, or a long hold when asked
   always @(negedge clock) begin
      if (reset || hold_rsp) begin
         rsp_tready <= 0;
      end else if (rsp_gap > 0) begin
         rsp_gap    <= rsp_gap - 1;
         rsp_tready <= 0;
      end else if (rsp_idle_on && $urandom_range(0, 3) == 0) begin
         rsp_gap    <= $urandom_range(0, 5);
         rsp_tready <= 0;
      end else begin
         rsp_tready <= 1;
      end
   end

   // check each response against the oldest prediction
   always @(posedge clock) begin
      zone_avg_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[4:0], rsp_tdata[20:5], rsp_tdata[36:21], rsp_tdata[52:37],
                rsp_tdata[68:53]};
         if (avg_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", rsp_tdata);
         end else begin
            want = avg_queue.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected n=%0d %h %h %h %h, got n=%0d %h %h %h %h",
                     want.active, want.wet, want.dry, want.room, want.damp,
                     got.active, got.wet, got.dry, got.room, got.damp);
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || hold_rsp)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_MAX) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      for (int k = 0; k < NZ; k++) begin
         zon_en[k] = 0; zon_shp[k] = 0; ctr_set[k] = 0; lvl_set[k] = 0;
         for (int i = 0; i < 3; i++) begin zon_ctr[k][i] = 0; zon_ext[k][i] = 0; end
         for (int i = 0; i < 4; i++) zon_lvl[k][i] = 0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      test_directed();
      test_random(310);
      test_backpressure();
      req_tvalid <= 0;
      for (int i = 0; i < 400; i++) @(negedge clock);
      test_random(260);
      req_idle_on = 0;
      rsp_idle_on = 0;
      test_random(110);
      req_tvalid <= 0;
      wait_drained();
      repeat (300) @(negedge clock);
      if (mismatches == 0 && avg_queue.size() == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule

`default_nettype wire

// ----- reverb_zone_containment_average.f -----
design/rzca_pkg.sv
design/rzca_ctrl.sv
design/rzca_datapath.sv
design/reverb_zone_containment_average.sv
sim/tb.sv
